// ----- design/ffud_pkg.sv -----
`timescale 1ns / 1ps

package ffud_pkg;

  localparam int KeyBytes = 16;
  localparam int MaxCapacity = 256;

  localparam int KeyLenW = 5;
  localparam int CapW = 9;
  localparam int CntW = $clog2(MaxCapacity + 1);
  localparam int CmpW = ((CntW > CapW) ? CntW : CapW) + 1;
  localparam int AddrW = 5;
  localparam int DataW = 64;

  localparam logic [KeyLenW-1:0] KeyBytesLen = KeyLenW'(KeyBytes);
  localparam logic [CapW-1:0] CapacityReset = CapW'(256);

  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChAmp = 8'h26;
  localparam logic [7:0] ChEquals = 8'h3d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [3:0] HexLetterBase = 4'd10;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2,
    REG_CAPACITY = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_KEY    = 3'd0,
    PH_SKIP   = 3'd1,
    PH_VALUE  = 3'd2,
    PH_ESC_HI = 3'd3,
    PH_ESC_LO = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_BAD_ESCAPE = 3'd2,
    ST_ZERO_BYTE  = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] form_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        key_low;
    logic [63:0]        key_high;
    logic [KeyLenW-1:0] key_len;
    logic [CapW-1:0]    capacity;
  } cfg_t;

endpackage

// ----- design/ffud_regs.sv -----
`timescale 1ns / 1ps

module ffud_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffud_pkg::AddrW-1:0]   paddr,
  input  logic [ffud_pkg::DataW-1:0]   pwdata,
  output logic [ffud_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output ffud_pkg::cfg_t               cfg_o
);

  ffud_pkg::cfg_t   cfg_q, cfg_d;
  ffud_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = ffud_pkg::reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ffud_pkg::REG_KEY_LOW:  cfg_d.key_low = pwdata;
        ffud_pkg::REG_KEY_HIGH: cfg_d.key_high = pwdata;
        ffud_pkg::REG_KEY_LEN:  cfg_d.key_len = pwdata[ffud_pkg::KeyLenW-1:0];
        ffud_pkg::REG_CAPACITY: cfg_d.capacity = pwdata[ffud_pkg::CapW-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ffud_pkg::REG_KEY_LOW:  prdata = cfg_q.key_low;
      ffud_pkg::REG_KEY_HIGH: prdata = cfg_q.key_high;
      ffud_pkg::REG_KEY_LEN:  prdata = ffud_pkg::DataW'(cfg_q.key_len);
      ffud_pkg::REG_CAPACITY: prdata = ffud_pkg::DataW'(cfg_q.capacity);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_low  <= '0;
      cfg_q.key_high <= '0;
      cfg_q.key_len  <= '0;
      cfg_q.capacity <= ffud_pkg::CapacityReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/ffud_core.sv -----
`timescale 1ns / 1ps

module ffud_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ffud_pkg::in_item_t   item_i,
  input  ffud_pkg::cfg_t       cfg_i,
  output logic                 res_valid_o,
  output ffud_pkg::out_item_t  res_o
);

  ffud_pkg::phase_e              phase_q, phase_d;
  logic [ffud_pkg::KeyLenW-1:0]  key_pos_q, key_pos_d;
  logic                          key_mism_q, key_mism_d;
  logic [3:0]                    high_nib_q, high_nib_d;
  logic [ffud_pkg::CntW-1:0]     used_q, used_d;
  logic                          settled_q, settled_d;

  logic [7:0]                    b;
  logic                          last;
  logic                          emit, done;
  logic [7:0]                    val;
  ffud_pkg::status_e             status;
  logic [7:0]                    key_byte;
  logic [127:0]                  key_all;
  logic                          nib_ok;
  logic [3:0]                    nib;
  logic [ffud_pkg::CmpW-1:0]     cap_ext, max_ext, eff_cap, used_inc;

  function automatic ffud_pkg::status_e end_status(ffud_pkg::phase_e ph);
    ffud_pkg::status_e s;
    if (ph == ffud_pkg::PH_VALUE) s = ffud_pkg::ST_OK;
    else if (ph == ffud_pkg::PH_ESC_HI || ph == ffud_pkg::PH_ESC_LO)
      s = ffud_pkg::ST_BAD_ESCAPE;
    else s = ffud_pkg::ST_NOT_FOUND;
    return s;
  endfunction

  assign b        = item_i.form_byte;
  assign last     = item_i.last;
  assign key_all  = {cfg_i.key_high, cfg_i.key_low};
  assign key_byte = key_all[key_pos_q[3:0]*8 +: 8];

  assign cap_ext  = ffud_pkg::CmpW'(cfg_i.capacity);
  assign max_ext  = ffud_pkg::CmpW'(ffud_pkg::MaxCapacity);
  assign eff_cap  = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign used_inc = ffud_pkg::CmpW'(used_q) + ffud_pkg::CmpW'(1);

  // hex digit, either case
  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (b >= "0" && b <= "9") begin
      nib = b[3:0];
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      nib = 4'(b[2:0] - 3'd1) + ffud_pkg::HexLetterBase;
    end else begin
      nib_ok = 1'b0;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    key_pos_d  = key_pos_q;
    key_mism_d = key_mism_q;
    high_nib_d = high_nib_q;
    used_d     = used_q;
    settled_d  = settled_q;
    emit       = 1'b0;
    done       = 1'b0;
    val        = 8'd0;
    status     = ffud_pkg::ST_OK;

    if (step_i && !settled_q) begin
      if (b == 8'd0) begin
        done   = 1'b1;
        status = end_status(phase_q);
      end else begin
        unique case (phase_q)
          ffud_pkg::PH_KEY: begin
            if (b == ffud_pkg::ChAmp) begin
              key_pos_d  = '0;
              key_mism_d = 1'b0;
            end else if (b == ffud_pkg::ChEquals) begin
              if (!key_mism_q && key_pos_q == cfg_i.key_len &&
                  cfg_i.key_len <= ffud_pkg::KeyBytesLen) begin
                phase_d = ffud_pkg::PH_VALUE;
                used_d  = '0;
                if (eff_cap == '0) begin
                  done   = 1'b1;
                  status = ffud_pkg::ST_TOO_LONG;
                end
              end else begin
                phase_d = ffud_pkg::PH_SKIP;
              end
            end else if (!key_mism_q) begin
              if (key_pos_q >= cfg_i.key_len || key_pos_q >= ffud_pkg::KeyBytesLen ||
                  b != key_byte) begin
                key_mism_d = 1'b1;
              end else begin
                key_pos_d = key_pos_q + ffud_pkg::KeyLenW'(1);
              end
            end
          end
          ffud_pkg::PH_SKIP: begin
            if (b == ffud_pkg::ChAmp) begin
              phase_d    = ffud_pkg::PH_KEY;
              key_pos_d  = '0;
              key_mism_d = 1'b0;
            end
          end
          ffud_pkg::PH_VALUE: begin
            if (b == ffud_pkg::ChAmp) begin
              done   = 1'b1;
              status = ffud_pkg::ST_OK;
            end else if (b == ffud_pkg::ChPercent) begin
              phase_d = ffud_pkg::PH_ESC_HI;
            end else begin
              val  = (b == ffud_pkg::ChPlus) ? ffud_pkg::ChSpace : b;
              emit = 1'b1;
            end
          end
          ffud_pkg::PH_ESC_HI, ffud_pkg::PH_ESC_LO: begin
            if (!nib_ok) begin
              done   = 1'b1;
              status = ffud_pkg::ST_BAD_ESCAPE;
            end else if (phase_q == ffud_pkg::PH_ESC_HI) begin
              high_nib_d = nib;
              phase_d    = ffud_pkg::PH_ESC_LO;
            end else begin
              val     = {high_nib_q, nib};
              phase_d = ffud_pkg::PH_VALUE;
              emit    = 1'b1;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end

      if (emit) begin
        if (val == 8'd0) begin
          emit   = 1'b0;
          done   = 1'b1;
          status = ffud_pkg::ST_ZERO_BYTE;
        end else if (used_inc >= eff_cap) begin
          emit   = 1'b0;
          done   = 1'b1;
          status = ffud_pkg::ST_TOO_LONG;
        end else begin
          used_d = used_q + ffud_pkg::CntW'(1);
        end
      end

      if (!done && last) begin
        done   = 1'b1;
        status = end_status(phase_d);
      end
      if (done && !last) settled_d = 1'b1;
    end

    // end of form, ready for the next one
    if (step_i && last) begin
      phase_d    = ffud_pkg::PH_KEY;
      key_pos_d  = '0;
      key_mism_d = 1'b0;
      high_nib_d = '0;
      used_d     = '0;
      settled_d  = 1'b0;
    end
  end

  assign res_valid_o      = emit | done;
  assign res_o.value_byte = emit ? val : 8'd0;
  assign res_o.byte_valid = emit;
  assign res_o.done_res   = done;
  assign res_o.status     = done ? status : ffud_pkg::ST_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ffud_pkg::PH_KEY;
      key_pos_q  <= '0;
      key_mism_q <= 1'b0;
      high_nib_q <= '0;
      used_q     <= '0;
      settled_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      key_pos_q  <= key_pos_d;
      key_mism_q <= key_mism_d;
      high_nib_q <= high_nib_d;
      used_q     <= used_d;
      settled_q  <= settled_d;
    end
  end

  a_settled_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |-> !res_valid_o)
    else $error("result produced after outcome settled");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit) |=> (ffud_pkg::CmpW'(used_q) < eff_cap))
    else $error("value byte count reached capacity");

endmodule

// ----- design/ffud_queue.sv -----
`timescale 1ns / 1ps

module ffud_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ffud_pkg::out_item_t  push_item_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ffud_pkg::out_item_t  out_item_o
);

  ffud_pkg::out_item_t mem_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                pop;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result pushed into full queue");

  a_count_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ----- design/form_field_url_decoder_top.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake                 | payload
// -------- | --------- | ------------------------- | -------------------------------
// in       | input     | in_valid_i / in_stall_o   | in_item_i  (form_byte, last)
// out      | output    | out_valid_o / out_stall_i | out_item_o (value, flags, status)
// config   | input     | apb, pready always high   | 64-bit registers at 8*index
//
// one form byte per cycle sustained while the result queue has room; a byte passes
// through the input register ahead of the decode logic on its way to the result queue
// the two-entry result queue lets input continue while a result waits
// input stalls only when a byte is held and the result queue is full
// reset clears control state and sets capacity to 256, all else zero

module form_field_url_decoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ffud_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ffud_pkg::out_item_t               out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ffud_pkg::AddrW-1:0]        paddr,
  input  logic [ffud_pkg::DataW-1:0]        pwdata,
  output logic [ffud_pkg::DataW-1:0]        prdata,
  output logic                              pready
);

  ffud_pkg::cfg_t      cfg;
  ffud_pkg::in_item_t  in_item_q;
  logic                in_vld_q, in_vld_d;
  logic                full;
  logic                step;
  logic                accept;
  logic                res_valid;
  ffud_pkg::out_item_t res;

  assign step       = in_vld_q & ~full;
  assign in_stall_o = in_vld_q & full;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) in_vld_d = 1'b1;
    else if (step) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_item_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  ffud_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ffud_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ffud_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step & res_valid),
    .push_item_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- sim/form_field_url_decoder_top_tb.sv -----
`timescale 1ns / 1ps

module form_field_url_decoder_top_tb;
  import ffud_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 120;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  form_field_url_decoder_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // register copies
  logic [63:0] key_lo_r = '0;
  logic [63:0] key_hi_r = '0;
  logic [KeyLenW-1:0] key_len_r = '0;
  logic [CapW-1:0] cap_r = CapacityReset;

  // decoder state copies
  phase_e scan_ph = PH_KEY;
  int key_pos = 0;
  bit key_miss = 1'b0;
  int hi_nib = 0;
  int val_len = 0;
  bit settled_q = 1'b0;

  out_item_t pending_results[$];
  logic [7:0] form_q[$];
  logic [7:0] key_b[KeyBytes];

  int err_cnt = 0;
  int sent_cnt = 0;
  int quiet_cnt = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  function automatic void rearm_scan();
    scan_ph = PH_KEY;
    key_pos = 0;
    key_miss = 1'b0;
    hi_nib = 0;
    val_len = 0;
    settled_q = 1'b0;
  endfunction

  function automatic int hex_val(int b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return 16;
  endfunction

  function automatic status_e end_status();
    if (scan_ph == PH_VALUE) return ST_OK;
    if (scan_ph == PH_ESC_HI || scan_ph == PH_ESC_LO) return ST_BAD_ESCAPE;
    return ST_NOT_FOUND;
  endfunction

  function automatic logic [7:0] key_char(int pos);
    if (pos < 8) return key_lo_r[8*pos +: 8];
    return key_hi_r[8*(pos-8) +: 8];
  endfunction

  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    int b;
    int n;
    int val;
    int lim;
    bit emit;
    bit done;
    status_e st;
    res = '0;
    b = it.form_byte;
    emit = 1'b0;
    done = 1'b0;
    val = 0;
    st = ST_OK;
    if (settled_q) begin
      if (it.last) rearm_scan();
      return 1'b0;
    end
    lim = (cap_r > MaxCapacity) ? MaxCapacity : int'(cap_r);
    if (b == 0) begin
      done = 1'b1;
      st = end_status();
    end else if (scan_ph == PH_KEY) begin
      if (b == ChAmp) begin
        key_pos = 0;
        key_miss = 1'b0;
      end else if (b == ChEquals) begin
        if (!key_miss && key_pos == key_len_r && key_len_r <= KeyBytes) begin
          scan_ph = PH_VALUE;
          val_len = 0;
          if (lim == 0) begin
            done = 1'b1;
            st = ST_TOO_LONG;
          end
        end else begin
          scan_ph = PH_SKIP;
        end
      end else if (!key_miss) begin
        if (key_pos >= key_len_r || key_pos >= KeyBytes || b != key_char(key_pos))
          key_miss = 1'b1;
        else
          key_pos++;
      end
    end else if (scan_ph == PH_SKIP) begin
      if (b == ChAmp) begin
        scan_ph = PH_KEY;
        key_pos = 0;
        key_miss = 1'b0;
      end
    end else if (scan_ph == PH_VALUE && b == ChAmp) begin
      done = 1'b1;
      st = ST_OK;
    end else if (scan_ph == PH_VALUE && b == ChPercent) begin
      scan_ph = PH_ESC_HI;
    end else if (scan_ph == PH_ESC_HI || scan_ph == PH_ESC_LO) begin
      n = hex_val(b);
      if (n > 15) begin
        done = 1'b1;
        st = ST_BAD_ESCAPE;
      end else if (scan_ph == PH_ESC_HI) begin
        hi_nib = n;
        scan_ph = PH_ESC_LO;
      end else begin
        val = (hi_nib << 4) | n;
        scan_ph = PH_VALUE;
        emit = 1'b1;
      end
    end else begin
      val = (b == ChPlus) ? int'(ChSpace) : b;
      emit = 1'b1;
    end
    if (emit) begin
      if (val == 0) begin
        emit = 1'b0;
        done = 1'b1;
        st = ST_ZERO_BYTE;
      end else if (val_len + 1 >= lim) begin
        emit = 1'b0;
        done = 1'b1;
        st = ST_TOO_LONG;
      end else begin
        val_len++;
      end
    end
    if (!done && it.last) begin
      done = 1'b1;
      st = end_status();
    end
    if (done) begin
      if (it.last) rearm_scan();
      else settled_q = 1'b1;
    end
    res.value_byte = emit ? val[7:0] : 8'h00;
    res.byte_valid = emit;
    res.done_res = done;
    res.status = done ? st : ST_OK;
    return emit || done;
  endfunction

  function automatic logic [63:0] reg_value(reg_idx_e idx);
    case (idx)
      REG_KEY_LOW:  return key_lo_r;
      REG_KEY_HIGH: return key_hi_r;
      REG_KEY_LEN:  return 64'(key_len_r);
      default:      return 64'(cap_r);
    endcase
  endfunction

  // result checking and receiver stall
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, none pending", '0, out_item_o);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.value_byte !== want.value_byte)
          report("value_byte", want.value_byte, out_item_o.value_byte);
        if (out_item_o.byte_valid !== want.byte_valid)
          report("byte_valid", want.byte_valid, out_item_o.byte_valid);
        if (out_item_o.done_res !== want.done_res)
          report("done_res", want.done_res, out_item_o.done_res);
        if (out_item_o.status !== want.status)
          report("status", want.status, out_item_o.status);
      end
    end
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || (!calm_out && $urandom_range(0, 99) < 7);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QuietLimit) begin
      $display("%0t: watchdog timeout, %0d results pending", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic send_byte(in_item_t it);
    out_item_t res;
    while (!calm_in && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    if (decode_byte(it, res)) pending_results.push_back(res);
  endtask

  task automatic send_form();
    in_item_t it;
    for (int i = 0; i < form_q.size(); i++) begin
      it.form_byte = form_q[i];
      it.last = (i == form_q.size() - 1);
      send_byte(it);
    end
    form_q.delete();
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input reg_idx_e idx, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= AddrW'({idx, 3'b000});
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(reg_idx_e idx);
    logic [63:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx)) report($sformatf("register %s", idx.name()), reg_value(idx), rd);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    logic [63:0] rd;
    wait_quiet();
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_KEY_LOW:  key_lo_r = val;
      REG_KEY_HIGH: key_hi_r = val;
      REG_KEY_LEN:  key_len_r = val[KeyLenW-1:0];
      default:      cap_r = val[CapW-1:0];
    endcase
    check_reg(idx);
  endtask

  task automatic apply_config(int len, int cap);
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = key_b[i];
      hi[8*i +: 8] = key_b[i+8];
    end
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LEN, 64'(len));
    write_reg(REG_CAPACITY, 64'(cap));
  endtask

  function automatic logic [7:0] ident_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(97, 122));
      1:       return 8'($urandom_range(65, 90));
      default: return 8'($urandom_range(48, 57));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == ChAmp || c == ChPercent || c == ChPlus || c == ChEquals);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(int n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  task automatic make_key(bit all_ones);
    for (int i = 0; i < KeyBytes; i++) key_b[i] = all_ones ? 8'hff : ident_char();
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) form_q.push_back(s[i]);
  endtask

  task automatic add_plain(int n);
    repeat (n) form_q.push_back(plain_char());
  endtask

  task automatic add_value(int len);
    int r;
    int hv;
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        form_q.push_back(ChEquals);
      end else if (r < 55) begin
        form_q.push_back(plain_char());
      end else if (r < 67) begin
        form_q.push_back(ChPlus);
      end else if (r < 87) begin
        hv = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 255);
        form_q.push_back(ChPercent);
        form_q.push_back(hex_char(hv >> 4));
        form_q.push_back(hex_char(hv & 15));
      end else if (r < 93) begin
        // broken escape: lone percent, non-hex digit, or one good digit then junk
        form_q.push_back(ChPercent);
        hv = $urandom_range(0, 2);
        if (hv == 2) form_q.push_back(hex_char($urandom_range(0, 15)));
        if (hv != 0) form_q.push_back(8'($urandom_range(103, 122)));
      end else begin
        form_q.push_back(8'($urandom_range(128, 255)));
      end
    end
  endtask

  task automatic add_segment();
    int r;
    int k;
    int j;
    int len;
    k = (key_len_r > KeyBytes) ? KeyBytes : int'(key_len_r);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 7);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      for (int i = 0; i < k; i++) form_q.push_back(key_b[i]);
      form_q.push_back(ChEquals);
      add_value(len);
    end else if (r < 60) begin
      j = (k > 0) ? $urandom_range(0, k - 1) : 0;
      case ($urandom_range(0, 2))
        0: for (int i = 0; i + 1 < k; i++) form_q.push_back(key_b[i]);
        1: begin
          for (int i = 0; i < k; i++) form_q.push_back(key_b[i]);
          form_q.push_back(ident_char());
        end
        default:
          for (int i = 0; i < k; i++) form_q.push_back((i == j) ? key_b[i] ^ 8'h01 : key_b[i]);
      endcase
      form_q.push_back(ChEquals);
      add_value(len);
    end else if (r < 75) begin
      add_plain($urandom_range(1, 6));
    end else if (r < 85) begin
      // empty segment
    end else begin
      form_q.push_back(ChEquals);
      add_value(len);
    end
  endtask

  task automatic build_form();
    int r;
    int nseg;
    nseg = $urandom_range(1, 4);
    for (int i = 0; i < nseg; i++) begin
      if (i > 0) form_q.push_back(ChAmp);
      add_segment();
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      form_q.push_back(8'h00);
      add_plain($urandom_range(0, 3));
    end else if (r < 18 && form_q.size() > 2) begin
      void'(form_q.pop_back());
      if ($urandom_range(0, 1)) void'(form_q.pop_back());
    end else if (r < 24) begin
      form_q.push_back(8'h00);
    end
    if (form_q.size() == 0) form_q.push_back(plain_char());
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 10)) form_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_reset_values();
    check_reg(REG_KEY_LOW);
    check_reg(REG_KEY_HIGH);
    check_reg(REG_KEY_LEN);
    check_reg(REG_CAPACITY);
  endtask

  task automatic test_directed();
    make_key(1'b0);
    key_b[0] = "a";
    key_b[1] = "b";
    apply_config(2, 256);
    // segment without equals, an escape with a lowercase hex digit, plus ending on last
    form_q.push_back(8'hff);
    push_str("&ab=%4a+");
    send_form();
    // escape cut short by separator
    push_str("ab=%0&");
    send_form();
    // zero byte ends an unmatched form, the rest is ignored
    push_str("q=1");
    form_q.push_back(8'h00);
    push_str("z");
    send_form();
    // decoded zero
    push_str("ab=%00y");
    send_form();
    // non-hex digit
    push_str("ab=%g");
    send_form();
  endtask

  task automatic test_capacity_limits();
    make_key(1'b0);
    key_b[0] = "k";
    apply_config(1, 0);
    push_str("k=z");
    send_form();
    apply_config(1, 511);
    push_str("k=");
    add_plain(MaxCapacity - 1);
    send_form();
    push_str("k=");
    add_plain(MaxCapacity + 2);
    send_form();
    apply_config(1, 1);
    push_str("k=x");
    send_form();
    apply_config(1, 2);
    push_str("k=xy");
    send_form();
  endtask

  task automatic test_backpressure();
    make_key(1'b0);
    key_b[0] = "k";
    apply_config(1, 256);
    calm_in = 1'b1;
    hold_req = 1'b1;
    push_str("k=");
    add_plain(60);
    send_form();
    calm_in = 1'b0;
  endtask

  task automatic test_random();
    int len;
    int cap;
    int stop_at;
    for (int p = 0; p < 9; p++) begin
      make_key(p == 7);
      case (p)
        0: begin len = $urandom_range(1, 16); cap = 256; end
        1: begin len = KeyBytes; cap = 1; end
        2: begin len = 0; cap = 2; end
        3: begin len = $urandom_range(1, 16); cap = 0; end
        4: begin len = KeyBytes + 1; cap = 511; end
        5: begin len = 31; cap = $urandom_range(3, 20); end
        6: begin len = $urandom_range(1, 4); cap = 256; end
        7: begin len = KeyBytes; cap = $urandom_range(1, 511); end
        default: begin len = $urandom_range(1, 16); cap = $urandom_range(3, 12); end
      endcase
      // one phase with no idling on either side
      calm_in = (p == 6);
      calm_out = (p == 6);
      apply_config(len, cap);
      stop_at = sent_cnt + 30;
      while (sent_cnt < stop_at) begin
        if ($urandom_range(0, 99) < 15) build_noise();
        else build_form();
        send_form();
      end
    end
    calm_in = 1'b0;
    calm_out = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_capacity_limits();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ffud_pkg.sv
design/ffud_regs.sv
design/ffud_core.sv
design/ffud_queue.sv
design/form_field_url_decoder_top.sv
sim/form_field_url_decoder_top_tb.sv
